>>> rtl/adf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and constants for the frame deframer: phase codes, status
// codes and the result record.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam logic [7:0]  PREAMBLE     = 8'hED;
  localparam logic [15:0] MAX_LEN_RST  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_KIND   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD      = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  frame_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        is_payload;
    logic        frame_end;
    status_t     frame_status;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/adf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_core
// Frame parser: phase sequencer, header/length/count/sum registers and the
// per-byte result, produced in the cycle the byte is accepted.
// ----------------------------------------------------------------------------
module adf_core #(
  parameter int unsigned LEN_BITS = adf_pkg::LEN_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [15:0]      max_len,
  output logic                  push,
  output adf_pkg::result_t      result
);

  localparam logic [15:0] LEN_CAP = 16'((32'd1 << LEN_BITS) - 32'd1);

  adf_pkg::phase_t     phase;
  adf_pkg::phase_t     phase_next;
  logic [7:0]          kind_reg;
  logic [7:0]          len_hi;
  logic [LEN_BITS-1:0] length_reg;
  logic [LEN_BITS-1:0] count_reg;
  logic [7:0]          running_sum;

  logic [15:0]         full_len;
  logic                too_long;
  logic [LEN_BITS-1:0] count_inc;

  assign full_len  = {len_hi, rx_byte};
  assign too_long  = (full_len > max_len) || (full_len > LEN_CAP);
  assign count_inc = count_reg + LEN_BITS'(1);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      adf_pkg::PH_HUNT:   phase_next = (rx_byte == adf_pkg::PREAMBLE) ?
                                       adf_pkg::PH_KIND : adf_pkg::PH_HUNT;
      adf_pkg::PH_KIND:   phase_next = adf_pkg::PH_LEN_HI;
      adf_pkg::PH_LEN_HI: phase_next = adf_pkg::PH_LEN_LO;
      adf_pkg::PH_LEN_LO: begin
        if (too_long)
          phase_next = adf_pkg::PH_HUNT;
        else if (full_len == 16'd0)
          phase_next = adf_pkg::PH_CHECK;
        else
          phase_next = adf_pkg::PH_DATA;
      end
      adf_pkg::PH_DATA:   phase_next = (count_inc >= length_reg) ?
                                       adf_pkg::PH_CHECK : adf_pkg::PH_DATA;
      adf_pkg::PH_CHECK:  phase_next = adf_pkg::PH_HUNT;
      default:            phase_next = (rx_byte == adf_pkg::PREAMBLE) ?
                                       adf_pkg::PH_KIND : adf_pkg::PH_HUNT;
    endcase
  end

  // result for the accepted byte
  always_comb begin
    push                = 1'b0;
    result.frame_kind   = kind_reg;
    result.payload_byte = 8'd0;
    result.byte_index   = 16'd0;
    result.is_payload   = 1'b0;
    result.frame_end    = 1'b0;
    result.frame_status = adf_pkg::ST_GOOD;
    unique case (phase)
      adf_pkg::PH_LEN_LO: begin
        push                = accept && too_long;
        result.frame_end    = 1'b1;
        result.frame_status = adf_pkg::ST_TOO_LONG;
      end
      adf_pkg::PH_DATA: begin
        push                = accept;
        result.payload_byte = rx_byte;
        result.byte_index   = 16'(count_reg);
        result.is_payload   = 1'b1;
      end
      adf_pkg::PH_CHECK: begin
        push                = accept;
        result.frame_end    = 1'b1;
        result.frame_status = (rx_byte == running_sum) ? adf_pkg::ST_GOOD
                                                       : adf_pkg::ST_BAD;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= adf_pkg::PH_HUNT;
      kind_reg    <= 8'd0;
      len_hi      <= 8'd0;
      length_reg  <= '0;
      count_reg   <= '0;
      running_sum <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      unique case (phase)
        adf_pkg::PH_KIND: begin
          kind_reg    <= rx_byte;
          running_sum <= running_sum + rx_byte;
        end
        adf_pkg::PH_LEN_HI: begin
          len_hi      <= rx_byte;
          running_sum <= running_sum + rx_byte;
        end
        adf_pkg::PH_LEN_LO: begin
          length_reg  <= full_len[LEN_BITS-1:0];
          count_reg   <= '0;
          running_sum <= running_sum + rx_byte;
        end
        adf_pkg::PH_DATA: begin
          count_reg   <= count_inc;
          running_sum <= running_sum + rx_byte;
        end
        adf_pkg::PH_CHECK: begin
          running_sum <= running_sum;
        end
        default: begin
          if (rx_byte == adf_pkg::PREAMBLE)
            running_sum <= adf_pkg::PREAMBLE;
        end
      endcase
    end
  end

  a_data_emits: assert property (@(posedge clk) disable iff (rst)
    accept && phase == adf_pkg::PH_DATA |-> push && result.is_payload)
    else $error("payload byte without result");

  a_check_ends: assert property (@(posedge clk) disable iff (rst)
    accept && phase == adf_pkg::PH_CHECK |=> phase == adf_pkg::PH_HUNT)
    else $error("checksum byte did not end frame");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == adf_pkg::PH_DATA |-> count_reg < length_reg)
    else $error("payload count past length");

endmodule
`default_nettype wire

>>> rtl/adf_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_outq
// Two-entry result queue between the parser and the result channel.
// ----------------------------------------------------------------------------
module adf_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire adf_pkg::result_t push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output adf_pkg::result_t      head
);

  adf_pkg::result_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= ~wr_ptr;
      if (pop)
        rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> rtl/api_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_deframer
// Byte-serial deframer: preamble hunt, type and length header, payload
// bytes out with index, additive checksum verdict at frame end.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  rx       rx_valid/rx_stall    rx_byte
//  res      res_valid/res_stall  frame_kind .. frame_status
//  cfg      cfg_valid/cfg_ready  cfg_data (max_payload_len)
//
//  One byte per cycle while rx_stall is low; each byte is parsed and any
//  result registered in the cycle it is accepted. A two-entry result queue
//  absorbs result stalls; rx_stall rises only when it is full. Synchronous
//  reset returns to preamble hunt with max_payload_len = 0xFFFF.
// ----------------------------------------------------------------------------
module api_frame_deframer #(
  parameter int unsigned LEN_BITS = adf_pkg::LEN_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       frame_kind,
  output logic [7:0]       payload_byte,
  output logic [15:0]      byte_index,
  output logic             is_payload,
  output logic             frame_end,
  output logic [1:0]       frame_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic             accept;
  logic             push;
  logic             q_full;
  adf_pkg::result_t core_res;
  adf_pkg::result_t head;
  logic [15:0]      max_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst)
      max_len <= adf_pkg::MAX_LEN_RST;
    else if (cfg_valid && cfg_ready)
      max_len <= cfg_data;
  end

  assign rx_stall = q_full;
  assign accept   = rx_valid && !rx_stall;

  adf_core #(.LEN_BITS(LEN_BITS)) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .max_len (max_len),
    .push    (push),
    .result  (core_res)
  );

  adf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_res),
    .pop       (res_valid && !res_stall),
    .full      (q_full),
    .not_empty (res_valid),
    .head      (head)
  );

  assign frame_kind   = head.frame_kind;
  assign payload_byte = head.payload_byte;
  assign byte_index   = head.byte_index;
  assign is_payload   = head.is_payload;
  assign frame_end    = head.frame_end;
  assign frame_status = head.frame_status;

endmodule
`default_nettype wire
